// ----- sv/dppc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppc_pkg: shared types and constants of the plane placement converter
// Fixed-point formats, CORDIC arctangent table and controller/datapath links.
// ----------------------------------------------------------------------------
package dppc_pkg;

    // Angles: 2^ANGLE_BITS per turn at the ports, 2^32 per turn in the CORDIC.
    localparam int ANGLE_BITS  = 16;
    localparam int ORIENT_BITS = ANGLE_BITS - 1;
    localparam int INNER_BITS  = 32;
    localparam int INNER_SHIFT = INNER_BITS - ANGLE_BITS;

    // Lengths are Q15.16; stored radii are unsigned.
    localparam int LEN_BITS = 31;
    localparam int OFS_BITS = 32;

    // CORDIC working widths (vectoring gain of 1.647 on a 32-bit magnitude).
    localparam int XY_BITS = 36;
    localparam int Z_BITS  = INNER_BITS + 1;

    // Gain removal: x * 1304065748 / 2^31, done as two 17-bit partial products.
    localparam int GAIN_BITS     = 31;
    localparam int GAIN_SHIFT    = 31;
    localparam int MUL_SRC_BITS  = 34;
    localparam int MUL_SPLIT     = 17;
    localparam int PART_BITS     = MUL_SPLIT + GAIN_BITS;
    localparam int ACC_BITS      = MUL_SRC_BITS + GAIN_BITS;
    localparam logic [GAIN_BITS-1:0] GAIN_Q31 = 31'd1304065748;

    localparam logic [LEN_BITS-1:0]    LEN_MAX     = '1;
    localparam logic [ORIENT_BITS-1:0] MINUS_QUARTER =
        ORIENT_BITS'(1) << (ORIENT_BITS - 1);

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [INNER_BITS-1:0] atan_step(input logic [4:0] idx);
        logic [INNER_BITS-1:0] a;
        unique case (idx)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            5'd30: a = 32'd1;
            5'd31: a = 32'd0;
        endcase
        return a;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture input transfer, update the form being set
        logic gain_lo;   // low partial product of gain removal
        logic gain_hi;   // high partial product, result into x
        logic iter;      // one CORDIC micro-rotation
        logic finish;    // derive other form, load output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic kind;      // 1: normal form was set (vectoring)
    } dp_status_t;

endpackage

// ----- sv/dppc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppc_ctrl: sequencer of the plane placement converter
// One-hot state machine, CORDIC step counter and output valid flag.
// ----------------------------------------------------------------------------
module dppc_ctrl #(
    parameter int CORDIC_STEPS = 16,
    parameter int STEP_W       = $clog2(CORDIC_STEPS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_kind,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output dppc_pkg::dp_cmd_t    cmd,
    output logic [STEP_W-1:0]    step_idx,
    input  dppc_pkg::dp_status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_GAIN_LO = 5'b00010,
        ST_GAIN_HI = 5'b00100,
        ST_ITER    = 5'b01000,
        ST_FINISH  = 5'b10000
    } state_t;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              fire;

    // result slot is free or being drained this cycle
    assign fire = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (s_tvalid) begin
                    state_next = s_kind ? ST_ITER : ST_GAIN_LO;
                end
            end
            ST_GAIN_LO: begin
                state_next = ST_GAIN_HI;
            end
            ST_GAIN_HI: begin
                state_next = status.kind ? ST_FINISH : ST_ITER;
            end
            ST_ITER: begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    step_next  = '0;
                    state_next = status.kind ? ST_GAIN_LO : ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready     = (state_reg == ST_IDLE);
    assign m_tvalid     = m_tvalid_reg;
    assign step_idx     = step_reg;
    assign cmd.load     = s_tready && s_tvalid;
    assign cmd.gain_lo  = (state_reg == ST_GAIN_LO);
    assign cmd.gain_hi  = (state_reg == ST_GAIN_HI);
    assign cmd.iter     = (state_reg == ST_ITER);
    assign cmd.finish   = fire;

`ifndef SYNTHESIS
    // an accepted transfer makes the block busy
    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_tready)
        else $error("input still ready after a transfer");

    // a new result only appears after a finish step
    a_valid_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(cmd.finish))
        else $error("result valid without finish");

    // gain removal is followed by the CORDIC run or by the finish step
    a_gain_then: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.gain_hi |=> (state_reg == ST_ITER || state_reg == ST_FINISH))
        else $error("bad state after gain removal");

    // the CORDIC run always starts at step zero
    a_iter_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.iter && !$past(cmd.iter)) |-> (step_reg == '0))
        else $error("CORDIC run entered at nonzero step");
`endif

endmodule

// ----- sv/dppc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppc_datapath: placement store, shared CORDIC unit and gain multiplier
// Holds both placement forms and derives one from the other on command.
// ----------------------------------------------------------------------------
module dppc_datapath #(
    parameter int CORDIC_STEPS = 16,
    parameter int STEP_W       = $clog2(CORDIC_STEPS)
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  dppc_pkg::dp_cmd_t                          cmd,
    input  logic [STEP_W-1:0]                          step_idx,
    input  logic                                       in_kind,
    input  logic signed [31:0]                         in_ref_angle,
    input  logic signed [31:0]                         in_radius,
    input  logic signed [31:0]                         in_third,
    output dppc_pkg::dp_status_t                       status,
    output logic [dppc_pkg::ANGLE_BITS-1:0]            out_center_angle,
    output logic [dppc_pkg::LEN_BITS-1:0]              out_center_radius,
    output logic signed [dppc_pkg::ORIENT_BITS-1:0]    out_center_orientation,
    output logic [dppc_pkg::ANGLE_BITS-1:0]            out_normal_angle,
    output logic [dppc_pkg::LEN_BITS-1:0]              out_normal_radius,
    output logic signed [dppc_pkg::OFS_BITS-1:0]       out_normal_offset
);

    localparam int AB = dppc_pkg::ANGLE_BITS;
    localparam int OB = dppc_pkg::ORIENT_BITS;
    localparam int LB = dppc_pkg::LEN_BITS;
    localparam int FB = dppc_pkg::OFS_BITS;
    localparam int XB = dppc_pkg::XY_BITS;
    localparam int ZB = dppc_pkg::Z_BITS;
    localparam int SH = dppc_pkg::INNER_SHIFT;
    localparam int MS = dppc_pkg::MUL_SPLIT;
    localparam int MB = dppc_pkg::MUL_SRC_BITS;
    localparam int PB = dppc_pkg::PART_BITS;
    localparam int CB = dppc_pkg::ACC_BITS;

    // placement store
    logic [AB-1:0]        st_ca_reg, st_ca_next;
    logic [LB-1:0]        st_cr_reg, st_cr_next;
    logic signed [OB-1:0] st_or_reg, st_or_next;
    logic [AB-1:0]        st_na_reg, st_na_next;
    logic [LB-1:0]        st_nr_reg, st_nr_next;
    logic signed [FB-1:0] st_no_reg, st_no_next;

    // CORDIC work registers
    logic                 kind_reg;
    logic signed [XB-1:0] x_reg, x_next;
    logic signed [XB-1:0] y_reg, y_next;
    logic signed [ZB-1:0] z_reg, z_next;
    logic [CB-1:0]        acc_reg;

    // output register
    logic [AB-1:0]        o_ca_reg;
    logic [LB-1:0]        o_cr_reg;
    logic signed [OB-1:0] o_or_reg;
    logic [AB-1:0]        o_na_reg;
    logic [LB-1:0]        o_nr_reg;
    logic signed [FB-1:0] o_no_reg;

    logic                 rad_ok;
    logic [OB-1:0]        in_orient;
    logic [LB-1:0]        new_nr;

    logic [MB-1:0]        mul_src;
    logic [MS-1:0]        mul_op;
    logic [PB-1:0]        mul_prod;
    logic [CB-1:0]        gain_sum;

    logic signed [XB-1:0] dx, dy;
    logic signed [ZB-1:0] atan_ext;
    logic                 rot_up;

    logic [LB-1:0]        clamp_x;
    logic [FB-1:0]        clamp_y;
    logic                 n_zero;
    logic [FB-1:0]        abs_ofs;
    logic [LB-1:0]        zero_cr;
    logic [OB-1:0]        zero_or;
    logic [ZB-1:0]        z_round;
    logic [OB-1:0]        vec_or;

    logic [AB-1:0]        fin_ca, fin_na;
    logic [LB-1:0]        fin_cr, fin_nr;
    logic [OB-1:0]        fin_or;
    logic [FB-1:0]        fin_no;

    assign rad_ok    = !in_radius[31];
    assign in_orient = in_third[OB-1:0];
    assign new_nr    = rad_ok ? in_radius[LB-1:0] : st_nr_reg;

    // gain removal multiplier, one partial product per cycle
    assign mul_src  = kind_reg ? x_reg[MB-1:0] : {{(MB-LB){1'b0}}, st_cr_reg};
    assign mul_op   = cmd.gain_lo ? mul_src[MS-1:0] : mul_src[MB-1:MS];
    assign mul_prod = mul_op * dppc_pkg::GAIN_Q31;
    assign gain_sum = acc_reg + {mul_prod, {MS{1'b0}}};

    // CORDIC micro-rotation; rotation follows z, vectoring drives y to zero
    assign dx       = y_reg >>> step_idx;
    assign dy       = x_reg >>> step_idx;
    assign atan_ext = $signed({1'b0, dppc_pkg::atan_step(5'(step_idx))});
    assign rot_up   = kind_reg ? y_reg[XB-1] : !z_reg[ZB-1];

    // saturation of the CORDIC results
    assign clamp_x = x_reg[XB-1] ? '0 :
                     (|x_reg[XB-2:LB]) ? dppc_pkg::LEN_MAX : x_reg[LB-1:0];
    assign clamp_y = (&y_reg[XB-1:FB-1] || !(|y_reg[XB-1:FB-1])) ? y_reg[FB-1:0] :
                     y_reg[XB-1] ? {1'b1, {(FB-1){1'b0}}} : {1'b0, {(FB-1){1'b1}}};

    // zero normal radius: the plane passes through the origin direction
    assign n_zero  = (st_nr_reg == '0);
    assign abs_ofs = st_no_reg[FB-1] ? (~st_no_reg + 1'b1) : st_no_reg;
    assign zero_cr = abs_ofs[FB-1] ? dppc_pkg::LEN_MAX : abs_ofs[LB-1:0];
    assign zero_or = (|st_no_reg) ? dppc_pkg::MINUS_QUARTER : '0;

    // round z to port angle units, keep a half turn
    assign z_round = z_reg + (ZB'(1) << (SH - 1));
    assign vec_or  = z_round[SH +: OB];

    always_comb begin
        fin_ca = st_ca_reg;
        fin_cr = st_cr_reg;
        fin_or = st_or_reg;
        fin_na = st_na_reg;
        fin_nr = st_nr_reg;
        fin_no = st_no_reg;
        if (kind_reg) begin
            fin_or = n_zero ? zero_or : vec_or;
            fin_cr = n_zero ? zero_cr : clamp_x;
            fin_ca = st_na_reg - {fin_or[OB-1], fin_or};
        end else begin
            fin_nr = clamp_x;
            fin_no = clamp_y;
        end
    end

    always_comb begin
        st_ca_next = st_ca_reg;
        st_cr_next = st_cr_reg;
        st_or_next = st_or_reg;
        st_na_next = st_na_reg;
        st_nr_next = st_nr_reg;
        st_no_next = st_no_reg;
        if (cmd.load) begin
            if (!in_kind) begin
                st_ca_next = in_ref_angle[AB-1:0];
                if (rad_ok) begin
                    st_cr_next = in_radius[LB-1:0];
                end
                st_or_next = in_orient;
                st_na_next = in_ref_angle[AB-1:0] + {in_orient[OB-1], in_orient};
            end else begin
                st_na_next = in_ref_angle[AB-1:0];
                st_nr_next = new_nr;
                st_no_next = in_third;
            end
        end else if (cmd.finish) begin
            st_ca_next = fin_ca;
            st_cr_next = fin_cr;
            st_or_next = fin_or;
            st_na_next = fin_na;
            st_nr_next = fin_nr;
            st_no_next = fin_no;
        end
    end

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (cmd.load) begin
            if (!in_kind) begin
                y_next = '0;
                z_next = {{(ZB-OB-SH){in_orient[OB-1]}}, in_orient, {SH{1'b0}}};
            end else begin
                x_next = {{(XB-LB){1'b0}}, new_nr};
                y_next = {{(XB-FB){in_third[FB-1]}}, in_third};
                z_next = '0;
            end
        end else if (cmd.gain_hi) begin
            x_next = {{(XB-MB){1'b0}}, gain_sum[CB-1:dppc_pkg::GAIN_SHIFT]};
        end else if (cmd.iter) begin
            if (rot_up) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_ext;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_ext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_ca_reg <= '0;
            st_cr_reg <= '0;
            st_or_reg <= '0;
            st_na_reg <= '0;
            st_nr_reg <= '0;
            st_no_reg <= '0;
        end else begin
            st_ca_reg <= st_ca_next;
            st_cr_reg <= st_cr_next;
            st_or_reg <= st_or_next;
            st_na_reg <= st_na_next;
            st_nr_reg <= st_nr_next;
            st_no_reg <= st_no_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (cmd.load) begin
            kind_reg <= in_kind;
        end
        if (cmd.gain_lo) begin
            acc_reg <= {{(CB-PB){1'b0}}, mul_prod};
        end
        if (cmd.finish) begin
            o_ca_reg <= fin_ca;
            o_cr_reg <= fin_cr;
            o_or_reg <= fin_or;
            o_na_reg <= fin_na;
            o_nr_reg <= fin_nr;
            o_no_reg <= fin_no;
        end
    end

    assign status.kind            = kind_reg;
    assign out_center_angle       = o_ca_reg;
    assign out_center_radius      = o_cr_reg;
    assign out_center_orientation = o_or_reg;
    assign out_normal_angle       = o_na_reg;
    assign out_normal_radius      = o_nr_reg;
    assign out_normal_offset      = o_no_reg;

endmodule

// ----- sv/detector_plane_placement_converter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detector_plane_placement_converter_unit: plane placement form converter
// Keeps a plane placement in center form and normal form and derives one
// from the other with a shared CORDIC unit.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: s_tuser selects the form being set (0 center, 1 normal);
//    s_tdata carries angle, radius and orientation or offset. A negative
//    radius keeps the stored radius of that form.
//  - Output stream: one transfer per input transfer with both forms.
//  - Sequence: a center-form input runs gain removal (low, then high
//    partial product), the CORDIC micro-rotations and a finish step; a
//    normal-form input runs the micro-rotations, then gain removal and
//    finish. The single iterative CORDIC unit works on one item at a time;
//    s_tready is high only while the sequencer is idle.
//  - The output register holds a finished result while the next item is
//    taken in and worked on; a further result waits in its finish step
//    until m_tready drains the register.
//  - Reset (aresetn low, synchronous) clears both stored forms to zero and
//    drops m_tvalid.
// ----------------------------------------------------------------------------
module detector_plane_placement_converter_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // [31:0] ref_angle, [63:32] radius_in,
                                    // [95:64] third_value
    input  logic [0:0]   s_tuser,   // [0] kind
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata    // [15:0] center_angle, [46:16] center_radius,
                                    // [61:47] center_orientation,
                                    // [77:62] normal_angle,
                                    // [108:78] normal_radius,
                                    // [140:109] normal_offset, [143:141] zero
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    dppc_pkg::dp_cmd_t    cmd;
    dppc_pkg::dp_status_t status;
    logic [STEP_W-1:0]    step_idx;

    logic [dppc_pkg::ANGLE_BITS-1:0]         center_angle;
    logic [dppc_pkg::LEN_BITS-1:0]           center_radius;
    logic signed [dppc_pkg::ORIENT_BITS-1:0] center_orientation;
    logic [dppc_pkg::ANGLE_BITS-1:0]         normal_angle;
    logic [dppc_pkg::LEN_BITS-1:0]           normal_radius;
    logic signed [dppc_pkg::OFS_BITS-1:0]    normal_offset;

    // sequencer: state machine, step counter, output valid
    dppc_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .STEP_W       (STEP_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .step_idx (step_idx),
        .status   (status)
    );

    // store, CORDIC and gain multiplier
    dppc_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .STEP_W       (STEP_W)
    ) u_datapath (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cmd                    (cmd),
        .step_idx               (step_idx),
        .in_kind                (s_tuser[0]),
        .in_ref_angle           (s_tdata[31:0]),
        .in_radius              (s_tdata[63:32]),
        .in_third               (s_tdata[95:64]),
        .status                 (status),
        .out_center_angle       (center_angle),
        .out_center_radius      (center_radius),
        .out_center_orientation (center_orientation),
        .out_normal_angle       (normal_angle),
        .out_normal_radius      (normal_radius),
        .out_normal_offset      (normal_offset)
    );

    // result packing, first field in the low bits
    assign m_tdata = {3'b000, normal_offset, normal_radius, normal_angle,
                      center_orientation, center_radius, center_angle};

endmodule

// ----- test/detector_plane_placement_converter_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detector_plane_placement_converter_unit_test: self-checking bench
// Drives center-form and normal-form placement transfers with random gaps and
// result back-pressure. A bit-exact integer CORDIC predictor tracks both
// stored forms. Every result transfer is checked field by field against the
// oldest predicted placement.
// ----------------------------------------------------------------------------
module detector_plane_placement_converter_unit_test;

    localparam int     CORDIC_STEPS = 16;
    localparam int     INNER_SHIFT  = 16;              // 2^32/turn inside, 2^16 at ports
    localparam longint QUARTER_TURN = 16384;
    localparam longint LEN_LIMIT    = 64'sh7FFF_FFFF;
    localparam longint OFS_CEIL     = 64'sh7FFF_FFFF;
    localparam longint OFS_FLOOR    = -(64'sd1 <<< 31);
    localparam longint unsigned GAIN_SCALE = 64'd1304065748;   // 0.60725293 * 2^31
    localparam int     RUN_LIMIT    = 200000;

    typedef enum logic {
        FORM_CENTER = 1'b0,
        FORM_NORMAL = 1'b1
    } form_kind_t;

    // Both forms, with the fields of m_tdata in reverse bit order
    typedef struct packed {
        logic [15:0]        center_angle;
        logic [30:0]        center_radius;
        logic signed [14:0] center_orientation;
        logic [15:0]        normal_angle;
        logic [30:0]        normal_radius;
        logic signed [31:0] normal_offset;
    } placement_t;

    // atan(2^-i), 2^32 per turn
    longint atan_turn32 [0:31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata  = '0;
    logic [0:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;

    placement_t   tracked_placement = '0;    // bench copy of both stored forms
    placement_t   expected_placements [$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           ready_wait  = 0;
    bit           no_idle     = 1'b0;        // set for back-to-back stretches

    detector_plane_placement_converter_unit #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint clamp_range(input longint v, input longint lo,
                                           input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Strip the CORDIC gain; negative magnitudes count as zero.
    function automatic longint scale_out_gain(input longint v);
        longint unsigned prod;
        if (v < 0) v = 0;
        prod = $unsigned(v) * GAIN_SCALE;
        return longint'(prod >> 31);
    endfunction

    // Applies one transfer to the tracked forms, returns the new placement.
    function automatic placement_t convert_placement(input form_kind_t kind,
            input logic signed [31:0] ang, input logic signed [31:0] rad,
            input logic signed [31:0] third);
        placement_t p;
        longint     x, y, z, dx, dy, o;
        p = tracked_placement;
        if (kind == FORM_CENTER) begin
            p.center_angle       = ang[15:0];
            if (rad >= 0) p.center_radius = rad[30:0];
            p.center_orientation = third[14:0];      // wraps into +-quarter turn
            p.normal_angle = p.center_angle
                           + {p.center_orientation[14], p.center_orientation};
            // rotation mode: (R, 0) turned by the orientation
            x = scale_out_gain(longint'(p.center_radius));
            y = 0;
            z = longint'($signed(p.center_orientation)) * (longint'(1) << INNER_SHIFT);
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_turn32[i];
                end else begin
                    x += dx; y -= dy; z += atan_turn32[i];
                end
            end
            p.normal_radius = 31'(clamp_range(x, 0, LEN_LIMIT));
            p.normal_offset = 32'(clamp_range(y, OFS_FLOOR, OFS_CEIL));
        end else begin
            p.normal_angle  = ang[15:0];
            if (rad >= 0) p.normal_radius = rad[30:0];
            p.normal_offset = third;
            if (p.normal_radius == 0) begin
                // on the normal axis: straight down the plane
                x = longint'(third);
                if (x < 0) x = -x;
                p.center_radius = 31'(clamp_range(x, 0, LEN_LIMIT));
                o = (third != 0) ? -QUARTER_TURN : 0;
            end else begin
                // vectoring mode: drive the offset to zero
                x = longint'(p.normal_radius);
                y = longint'(third);
                z = 0;
                for (int i = 0; i < CORDIC_STEPS; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y >= 0) begin
                        x += dx; y -= dy; z += atan_turn32[i];
                    end else begin
                        x -= dx; y += dy; z -= atan_turn32[i];
                    end
                end
                p.center_radius = 31'(clamp_range(scale_out_gain(x), 0, LEN_LIMIT));
                o = (z + (longint'(1) << (INNER_SHIFT - 1))) >>> INNER_SHIFT;
            end
            p.center_orientation = o[14:0];
            p.center_angle = p.normal_angle
                           - {p.center_orientation[14], p.center_orientation};
        end
        tracked_placement = p;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Returns at the edge the transfer happens; s_tvalid is left high so a
    // zero-gap follow-up keeps it high without a second update in the step.
    task automatic send_placement(input form_kind_t kind,
                                  input logic signed [31:0] ang,
                                  input logic signed [31:0] rad,
                                  input logic signed [31:0] third);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {third, rad, ang};
        do @(posedge aclk); while (!s_tready);
        expected_placements.push_back(convert_placement(kind, ang, rad, third));
    endtask

    // Sender goes quiet until every predicted placement has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_placements.size() != 0);
    endtask

    // Lengths biased toward zero, the extremes and negative (keep) values.
    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return $urandom_range(1, 255);
            2:       return 32'h7FFF_FFFF - $urandom_range(0, 255);
            3:       return 32'h8000_0000 | $urandom;
            4:       return -$urandom_range(1, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_placement();
        form_kind_t  kind;
        logic [31:0] third;
        kind  = form_kind_t'($urandom_range(0, 1));
        third = (kind == FORM_CENTER) ? $urandom : pick_length();
        send_placement(kind, $urandom, pick_length(), third);
    endtask

    // ------------------------------------------------------------------
    // Result side: after each transfer, hold m_tready low for a random stall,
    // counted down only while a result is waiting.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_sink
        int stall;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            m_tready   <= (stall == 0);
            ready_wait <= stall;
        end else if (!m_tready && (m_tvalid || ready_wait == 0)) begin
            if (ready_wait <= 1)
                m_tready <= 1'b1;
            else
                ready_wait <= ready_wait - 1;
        end
    end

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        placement_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.center_angle       = m_tdata[15:0];
            got.center_radius      = m_tdata[46:16];
            got.center_orientation = m_tdata[61:47];
            got.normal_angle       = m_tdata[77:62];
            got.normal_radius      = m_tdata[108:78];
            got.normal_offset      = m_tdata[140:109];
            if (expected_placements.size() == 0) begin
                $error("result transfer with no placement expected");
                error_count++;
            end else begin
                want = expected_placements.pop_front();
                check_field("center_angle", want.center_angle, got.center_angle);
                check_field("center_radius", want.center_radius, got.center_radius);
                check_field("center_orientation", want.center_orientation,
                            got.center_orientation);
                check_field("normal_angle", want.normal_angle, got.normal_angle);
                check_field("normal_radius", want.normal_radius, got.normal_radius);
                check_field("normal_offset", want.normal_offset, got.normal_offset);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("detector_plane_placement_converter_unit_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Center form: extreme angles, full radius, orientation wrap, keep radius
    task automatic test_center_form();
        send_placement(FORM_CENTER, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_placement(FORM_CENTER, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_placement(FORM_CENTER, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd16383);
        send_placement(FORM_CENTER, 32'h8000_0000, 32'hFFFF_FFFF, -32'sd16384);
        send_placement(FORM_CENTER, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_placement(FORM_CENTER, 32'h1234_5678, 32'h0001_0000, 32'h8000_0000);
        send_placement(FORM_CENTER, 32'h0000_0000, 32'h7FFF_FFFF, 32'd8192);
        // exactly a quarter turn wraps to minus a quarter
        send_placement(FORM_CENTER, 32'h0000_FFFF, 32'h0000_0000, 32'd16384);
    endtask

    // Normal form: zero normal radius, saturating hypotenuse, atan near +quarter
    task automatic test_normal_form();
        send_placement(FORM_NORMAL, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_placement(FORM_NORMAL, 32'h0000_0100, 32'h0000_0000, 32'h0005_0000);
        send_placement(FORM_NORMAL, 32'h0000_0200, 32'h0000_0000, 32'hFFFB_0000);
        send_placement(FORM_NORMAL, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
        send_placement(FORM_NORMAL, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_placement(FORM_NORMAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_placement(FORM_NORMAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_placement(FORM_NORMAL, 32'h0000_1234, 32'h0000_0001, 32'h7FFF_FFFF);
        send_placement(FORM_NORMAL, 32'h0000_4321, 32'hFFFF_FFFF, 32'h0001_0000);
        send_placement(FORM_NORMAL, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
        send_placement(FORM_NORMAL, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    endtask

    // Sender holds off until the block has fully drained
    task automatic test_drain_pause();
        repeat (8) send_random_placement();
        wait_for_results();
    endtask

    // No gaps on either side
    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (80) send_random_placement();
        no_idle = 1'b0;
    endtask

    task automatic test_random_placements();
        repeat (800) send_random_placement();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_center_form();
        test_normal_form();
        test_drain_pause();
        test_back_to_back();
        test_random_placements();

        wait_for_results();
        repeat (CORDIC_STEPS + 8) @(posedge aclk);
        if (error_count == 0)
            $display("detector_plane_placement_converter_unit_test: PASS");
        else
            $display("detector_plane_placement_converter_unit_test: FAIL");
        $finish;
    end

endmodule
